// File: rtl/csvbp_pkg.sv
// Shared types, character and event codes for the CSV byte stream parser.
`timescale 1ns / 1ps
package csvbp_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_FIELD = 3'd1;
  localparam logic [2:0] KIND_ROW   = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_NO_LF       = 3'd1;
  localparam logic [2:0] ERR_QUOTE_UNQ   = 3'd2;
  localparam logic [2:0] ERR_AFTER_QUOTE = 3'd3;
  localparam logic [2:0] ERR_UNTERM      = 3'd4;
  localparam logic [2:0] ERR_NO_MORE     = 3'd5;

  typedef enum logic [2:0] {
    MODE_FIELD  = 3'd0,
    MODE_ROW    = 3'd1,
    MODE_PLAIN  = 3'd2,
    MODE_QUOTED = 3'd3,
    MODE_QSEEN  = 3'd4,
    MODE_CRSEEN = 3'd5,
    MODE_DONE   = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } char_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
  } tok_item_t;

endpackage

// File: rtl/csvbp_step.sv
// Next-mode and event decode for one input character.
`timescale 1ns / 1ps
module csvbp_step (
  input  csvbp_pkg::mode_t      mode,
  input  csvbp_pkg::char_item_t item,
  output csvbp_pkg::mode_t      mode_next,
  output logic                  res_valid,
  output csvbp_pkg::tok_item_t  res
);

  logic [7:0] c;
  logic       eos;

  assign c   = item.data_byte;
  assign eos = item.end_of_stream;

  task automatic put(input logic [2:0] k, input logic [7:0] b, input logic [2:0] e);
    res_valid      = 1'b1;
    res.kind       = k;
    res.out_byte   = b;
    res.error_code = e;
  endtask

  always_comb begin
    mode_next = mode;
    res_valid = 1'b0;
    res       = '0;
    unique case (mode)
      csvbp_pkg::MODE_FIELD, csvbp_pkg::MODE_ROW, csvbp_pkg::MODE_PLAIN: begin
        if (eos) begin
          mode_next = csvbp_pkg::MODE_DONE;
          if (mode == csvbp_pkg::MODE_ROW) begin
            put(csvbp_pkg::KIND_DONE, 8'd0, csvbp_pkg::ERR_NONE);
          end else begin
            put(csvbp_pkg::KIND_ROW, 8'd0, csvbp_pkg::ERR_NONE);
          end
        end else if (c == csvbp_pkg::CH_COMMA) begin
          mode_next = csvbp_pkg::MODE_FIELD;
          put(csvbp_pkg::KIND_FIELD, 8'd0, csvbp_pkg::ERR_NONE);
        end else if (c == csvbp_pkg::CH_QUOTE) begin
          if (mode == csvbp_pkg::MODE_PLAIN) begin
            mode_next = csvbp_pkg::MODE_FIELD;
            put(csvbp_pkg::KIND_ERR, 8'd0, csvbp_pkg::ERR_QUOTE_UNQ);
          end else begin
            mode_next = csvbp_pkg::MODE_QUOTED;
          end
        end else if (c == csvbp_pkg::CH_CR) begin
          mode_next = csvbp_pkg::MODE_CRSEEN;
        end else if (c == csvbp_pkg::CH_LF) begin
          mode_next = csvbp_pkg::MODE_ROW;
          put(csvbp_pkg::KIND_ROW, 8'd0, csvbp_pkg::ERR_NONE);
        end else begin
          mode_next = csvbp_pkg::MODE_PLAIN;
          put(csvbp_pkg::KIND_BYTE, c, csvbp_pkg::ERR_NONE);
        end
      end
      csvbp_pkg::MODE_QUOTED: begin
        if (eos) begin
          mode_next = csvbp_pkg::MODE_DONE;
          put(csvbp_pkg::KIND_ERR, 8'd0, csvbp_pkg::ERR_UNTERM);
        end else if (c == csvbp_pkg::CH_QUOTE) begin
          mode_next = csvbp_pkg::MODE_QSEEN;
        end else begin
          put(csvbp_pkg::KIND_BYTE, c, csvbp_pkg::ERR_NONE);
        end
      end
      csvbp_pkg::MODE_QSEEN: begin
        if (eos) begin
          mode_next = csvbp_pkg::MODE_DONE;
          put(csvbp_pkg::KIND_ROW, 8'd0, csvbp_pkg::ERR_NONE);
        end else if (c == csvbp_pkg::CH_QUOTE) begin
          mode_next = csvbp_pkg::MODE_QUOTED;
          put(csvbp_pkg::KIND_BYTE, csvbp_pkg::CH_QUOTE, csvbp_pkg::ERR_NONE);
        end else if (c == csvbp_pkg::CH_COMMA) begin
          mode_next = csvbp_pkg::MODE_FIELD;
          put(csvbp_pkg::KIND_FIELD, 8'd0, csvbp_pkg::ERR_NONE);
        end else if (c == csvbp_pkg::CH_CR) begin
          mode_next = csvbp_pkg::MODE_CRSEEN;
        end else if (c == csvbp_pkg::CH_LF) begin
          mode_next = csvbp_pkg::MODE_ROW;
          put(csvbp_pkg::KIND_ROW, 8'd0, csvbp_pkg::ERR_NONE);
        end else begin
          mode_next = csvbp_pkg::MODE_FIELD;
          put(csvbp_pkg::KIND_ERR, 8'd0, csvbp_pkg::ERR_AFTER_QUOTE);
        end
      end
      csvbp_pkg::MODE_CRSEEN: begin
        if (eos) begin
          mode_next = csvbp_pkg::MODE_DONE;
          put(csvbp_pkg::KIND_ERR, 8'd0, csvbp_pkg::ERR_NO_LF);
        end else if (c == csvbp_pkg::CH_LF) begin
          mode_next = csvbp_pkg::MODE_ROW;
          put(csvbp_pkg::KIND_ROW, 8'd0, csvbp_pkg::ERR_NONE);
        end else begin
          mode_next = csvbp_pkg::MODE_FIELD;
          put(csvbp_pkg::KIND_ERR, 8'd0, csvbp_pkg::ERR_NO_LF);
        end
      end
      default: begin
        mode_next = csvbp_pkg::MODE_DONE;
        put(csvbp_pkg::KIND_ERR, 8'd0, csvbp_pkg::ERR_NO_MORE);
      end
    endcase
  end

endmodule

// File: rtl/csv_byte_stream_parser.sv
// Top level of the strict CSV byte stream parser.
//
// Input channel char_*: one item per character (data_byte) or an end mark
// (end_of_stream set). Output channel tok_*: zero or one token item per
// input item: content byte, field end, row end, stream done, or error.
// Both channels use valid/stall; an item moves when valid is high and
// stall is low.
// Throughput: one input item per cycle while char_stall is low. A token
// is registered into tok_item, or into the skid register behind an older
// token. The parse mode register and the combinational decode in
// csvbp_step settle each item; a two-entry output stage (output register
// plus a skid register) holds tokens while the receiver stalls.
// char_stall rises only when the skid register holds a token, so a stalled
// receiver stops the input once the skid register fills, without loss.
// Reset (rst, synchronous) returns the mode to field start and empties
// the output stage. After the end mark every item gives error 5.
`timescale 1ns / 1ps
module csv_byte_stream_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  csvbp_pkg::char_item_t char_item,
  output logic                  tok_valid,
  input  logic                  tok_stall,
  output csvbp_pkg::tok_item_t  tok_item
);

  csvbp_pkg::mode_t     mode;
  csvbp_pkg::mode_t     mode_next;
  logic                 res_valid;
  csvbp_pkg::tok_item_t res;
  logic                 skid_valid;
  csvbp_pkg::tok_item_t skid;
  logic                 accept;
  logic                 push;
  logic                 pop;

  csvbp_step u_step (
    .mode      (mode),
    .item      (char_item),
    .mode_next (mode_next),
    .res_valid (res_valid),
    .res       (res)
  );

  assign char_stall = skid_valid;
  assign accept     = char_valid && !char_stall;
  assign push       = accept && res_valid;
  assign pop        = tok_valid && !tok_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= csvbp_pkg::MODE_FIELD;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

  // Advance the output register from the skid register or the new token, or park the new token in the skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !tok_valid) begin
      if (skid_valid) begin
        tok_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        tok_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !tok_valid) begin
      if (skid_valid) begin
        tok_item <= skid;
        skid     <= res;
      end else if (push) begin
        tok_item <= res;
      end
    end else if (push) begin
      skid <= res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> tok_valid)
    else $error("skid register full while output register empty");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    mode == csvbp_pkg::MODE_DONE |=> mode == csvbp_pkg::MODE_DONE)
    else $error("parser left stream-ended mode");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> ((tok_item.kind == csvbp_pkg::KIND_ERR) ==
                   (tok_item.error_code != csvbp_pkg::ERR_NONE)))
    else $error("error code does not match token kind");

  a_stall_holds_token: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall && skid_valid |=> $stable(skid) && skid_valid)
    else $error("skid token lost while receiver stalls");

endmodule
